// ===== rtl/core/cmpl_pkg.sv =====
// cmpl_pkg: shared types and constants for the compacting array list.
// Holds the operation codes, the state encoding and the cell control struct.
// No dependencies.
package cmpl_pkg;

  localparam int CMPL_CAPACITY = 256;
  localparam int POS_W         = 8;
  localparam int VAL_W         = 32;
  localparam int FILL_W        = 9;
  localparam int TAP_GRP       = 16;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } cmpl_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAP,
    ST_GROUP,
    ST_OUT
  } cmpl_state_t;

  // Broadcast to every cell in the accept cycle
  typedef struct packed {
    logic             go;
    cmpl_kind_t       kind;
    logic [POS_W-1:0] pos;
  } cmpl_ctl_t;

endpackage

// ===== rtl/core/cmpl_cell.sv =====
// cmpl_cell: one list slot of the compacting array list.
// Loads an appended value, takes its upper neighbor on delete, taps on read.
// Depends on cmpl_pkg.
module cmpl_cell import cmpl_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 9
) (
  input  logic                    clk,
  input  cmpl_ctl_t               ctl,
  input  logic [CW-1:0]           count,
  input  logic signed [VAL_W-1:0] nbr_data,
  input  logic signed [VAL_W-1:0] in_value,
  output logic signed [VAL_W-1:0] data,
  output logic signed [VAL_W-1:0] tap
);

  localparam int XW = (CW > FILL_W) ? CW : FILL_W;

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] tap_r;
  logic [XW-1:0]           pos_x;
  logic [XW-1:0]           cnt_x;
  logic [XW-1:0]           idx_x;
  logic                    in_range;
  logic                    load;
  logic                    shift;
  logic                    hit;

  always_comb begin
    pos_x    = XW'(ctl.pos);
    cnt_x    = XW'(count);
    idx_x    = XW'(IDX);
    in_range = pos_x < cnt_x;
    load     = ctl.go && (ctl.kind == KIND_APPEND) && (cnt_x == idx_x);
    shift    = ctl.go && (ctl.kind == KIND_DELETE) && in_range && (idx_x >= pos_x);
    hit      = (ctl.kind == KIND_READ) && in_range && (pos_x == idx_x);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_value;
    end else if (shift) begin
      data_r <= nbr_data;
    end
    if (ctl.go) begin
      tap_r <= hit ? data_r : '0;
    end
  end

  assign data = data_r;
  assign tap  = tap_r;

endmodule

// ===== rtl/core/compacting_array_list.sv =====
// compacting_array_list: fixed-capacity ordered list of signed 32-bit words.
// Top level: a row of cmpl_cell slots, the read merge tree and the control FSM.
// Depends on cmpl_pkg and cmpl_cell.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------------
//   in_     | input     | in_valid / in_stall | in_kind, in_position, in_value
//   out_    | output    | out_valid/out_stall | out_read_value, out_fill_level,
//           |           |                     | out_accepted, out_has_next
//
// One beat in gives one beat out, and a beat holds the block through the accept
// cycle (cells update, read taps latch), group merge, final merge, then the
// result cycle. out_valid rises in the result state, behind the group and final
// merge registers, and holds until out_stall drops; the next beat is taken back in idle.
// Both merge steps belong to the read tap OR tree.
// in_stall is high after the accepting edge until the result beat is taken.
// rst_n (synchronous) empties the list and the FSM; slot contents are not cleared,
// since only slots below the fill level are ever read.
module compacting_array_list import cmpl_pkg::*; #(
  parameter int CAPACITY = CMPL_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_kind,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [VAL_W-1:0]  in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  out_read_value,
  output logic [FILL_W-1:0]        out_fill_level,
  output logic                     out_accepted,
  output logic                     out_has_next
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int XW   = (CW > FILL_W) ? CW : FILL_W;
  localparam int NGRP = (CAPACITY + TAP_GRP - 1) / TAP_GRP;

  cmpl_state_t state_r, state_nxt;

  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    ok;
  logic                    accept;
  cmpl_ctl_t               ctl;
  logic [XW-1:0]           pos_x;
  logic [XW-1:0]           cnt_x;
  logic [XW-1:0]           cnt_nxt_x;

  logic signed [VAL_W-1:0] slot   [CAPACITY];
  logic signed [VAL_W-1:0] tap    [CAPACITY];
  logic signed [VAL_W-1:0] grp_r  [NGRP];
  logic signed [VAL_W-1:0] grp_or [NGRP];
  logic signed [VAL_W-1:0] all_or;

  logic signed [VAL_W-1:0] rd_r;
  logic [FILL_W-1:0]       fill_r;
  logic                    ok_r;
  logic                    next_r;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  // Broadcast the beat to the row of slots
  always_comb begin
    ctl.go   = accept;
    ctl.kind = cmpl_kind_t'(in_kind);
    ctl.pos  = in_position;
  end

  // Fill level update and status flags
  always_comb begin
    pos_x   = XW'(in_position);
    cnt_x   = XW'(cnt_r);
    cnt_nxt = cnt_r;
    ok      = 1'b0;
    unique case (cmpl_kind_t'(in_kind))
      KIND_APPEND: begin
        if (cnt_r < CW'(CAPACITY)) begin
          cnt_nxt = cnt_r + 1'b1;
          ok      = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (pos_x < cnt_x) begin
          cnt_nxt = cnt_r - 1'b1;
          ok      = 1'b1;
        end
      end
      KIND_READ: begin
        ok = pos_x < cnt_x;
      end
      KIND_CLEAR: begin
        cnt_nxt = '0;
        ok      = 1'b1;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
    cnt_nxt_x = XW'(cnt_nxt);
  end

  // Row of slots: each takes its upper neighbor on delete; the top one holds
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] nbr;
    if (i == CAPACITY - 1) begin : g_top
      assign nbr = slot[i];
    end else begin : g_mid
      assign nbr = slot[i + 1];
    end
    cmpl_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (cnt_r),
      .nbr_data (nbr),
      .in_value (in_value),
      .data     (slot[i]),
      .tap      (tap[i])
    );
  end

  // Read merge: at most one tap is nonzero, so OR them in groups, then overall
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_or[g] = '0;
      for (int j = 0; j < TAP_GRP; j++) begin
        if (g * TAP_GRP + j < CAPACITY) begin
          grp_or[g] = grp_or[g] | tap[g * TAP_GRP + j];
        end
      end
    end
  end

  always_comb begin
    all_or = '0;
    for (int g = 0; g < NGRP; g++) begin
      all_or = all_or | grp_r[g];
    end
  end

  // FSM: accept, merge groups, merge all, offer the result
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_TAP;
      ST_TAP:   state_nxt = ST_GROUP;
      ST_GROUP: state_nxt = ST_OUT;
      ST_OUT:   if (!out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      fill_r <= cnt_nxt_x[FILL_W-1:0];
      ok_r   <= ok;
      next_r <= (pos_x + 1'b1) < cnt_nxt_x;
    end
    if (state_r == ST_TAP) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_or[g];
      end
    end
    if (state_r == ST_GROUP) begin
      rd_r <= all_or;
    end
  end

  assign out_read_value = rd_r;
  assign out_fill_level = fill_r;
  assign out_accepted   = ok_r;
  assign out_has_next   = next_r;

endmodule

// ===== verif/compacting_array_list_test.sv =====
// compacting_array_list_test: self-checking bench for the compacting array list.
// Drives directed and random list operations, predicts every result beat.
// Depends on cmpl_pkg and the compacting_array_list RTL.
`timescale 1ns / 100ps

module compacting_array_list_test;
  import cmpl_pkg::*;

  localparam int RANDOM_OPS   = 600;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_GAP      = 8;
  localparam int CYCLE_LIMIT  = 200000;

  // One result beat, fields in port order
  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [FILL_W-1:0]       fill_level;
    logic                    accepted;
    logic                    has_next;
  } list_result_t;

  // One operation beat; known_res is used in place of the prediction when set
  typedef struct packed {
    cmpl_kind_t              kind;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
    logic                    known;
    list_result_t            known_res;
  } list_op_t;

  localparam int N_DIRECTED = 24;

  // Directed walk: empty list, both value extremes, edges of the fill level,
  // out of range positions, ignored fields, middle/last deletes and clears.
  localparam list_op_t DIRECTED_OPS [N_DIRECTED] = '{
    '{KIND_READ,   8'd0,   32'h0000_0000, 1'b1, '{32'h0000_0000, 9'd0, 1'b0, 1'b0}},
    '{KIND_DELETE, 8'd0,   32'h0000_0000, 1'b1, '{32'h0000_0000, 9'd0, 1'b0, 1'b0}},
    '{KIND_READ,   8'd255, 32'h0000_0000, 1'b1, '{32'h0000_0000, 9'd0, 1'b0, 1'b0}},
    '{KIND_CLEAR,  8'd0,   32'h0000_0000, 1'b1, '{32'h0000_0000, 9'd0, 1'b1, 1'b0}},
    '{KIND_APPEND, 8'd255, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, 9'd1, 1'b1, 1'b0}},
    '{KIND_APPEND, 8'd0,   32'h8000_0000, 1'b1, '{32'h0000_0000, 9'd2, 1'b1, 1'b1}},
    '{KIND_APPEND, 8'd0,   32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 9'd3, 1'b1, 1'b1}},
    '{KIND_APPEND, 8'd2,   32'h0000_0000, 1'b1, '{32'h0000_0000, 9'd4, 1'b1, 1'b1}},
    '{KIND_READ,   8'd0,   32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 9'd4, 1'b1, 1'b1}},
    '{KIND_READ,   8'd1,   32'h5A5A_5A5A, 1'b1, '{32'h8000_0000, 9'd4, 1'b1, 1'b1}},
    '{KIND_READ,   8'd3,   32'h0000_0000, 1'b1, '{32'h0000_0000, 9'd4, 1'b1, 1'b0}},
    '{KIND_READ,   8'd4,   32'h0000_0000, 1'b1, '{32'h0000_0000, 9'd4, 1'b0, 1'b0}},
    '{KIND_READ,   8'd255, 32'h0000_0000, 1'b1, '{32'h0000_0000, 9'd4, 1'b0, 1'b0}},
    '{KIND_DELETE, 8'd1,   32'h0000_0000, 1'b0, '0},
    '{KIND_READ,   8'd1,   32'h0000_0000, 1'b0, '0},
    '{KIND_DELETE, 8'd255, 32'h0000_0000, 1'b0, '0},
    '{KIND_DELETE, 8'd2,   32'h0000_0000, 1'b0, '0},
    '{KIND_READ,   8'd0,   32'h0000_0000, 1'b0, '0},
    '{KIND_DELETE, 8'd0,   32'hFFFF_FFFF, 1'b0, '0},
    '{KIND_DELETE, 8'd0,   32'h0000_0000, 1'b0, '0},
    '{KIND_APPEND, 8'd17,  32'h1234_5678, 1'b0, '0},
    '{KIND_CLEAR,  8'd255, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 9'd0, 1'b1, 1'b0}},
    '{KIND_APPEND, 8'd0,   32'hA5A5_A5A5, 1'b0, '0},
    '{KIND_CLEAR,  8'd0,   32'h0000_0000, 1'b1, '{32'h0000_0000, 9'd0, 1'b1, 1'b0}}
  };

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    in_valid       = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_kind        = KIND_APPEND;
  logic [POS_W-1:0]        in_position    = '0;
  logic signed [VAL_W-1:0] in_value       = '0;
  logic                    out_valid;
  logic                    out_stall      = 1'b0;
  logic signed [VAL_W-1:0] out_read_value;
  logic [FILL_W-1:0]       out_fill_level;
  logic                    out_accepted;
  logic                    out_has_next;

  // Shadow copy of the list, advanced as each beat is accepted
  logic signed [VAL_W-1:0] shadow_words [CMPL_CAPACITY];
  int                      shadow_count = 0;

  list_result_t pending_results [$];
  int           fail_count     = 0;
  int           cycle_count    = 0;
  int           send_idle_pct  = 0;
  int           recv_idle_pct  = 0;
  bit           hold_request   = 1'b0;
  bit           hold_done      = 1'b0;
  int           hold_left      = 0;

  compacting_array_list dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_fill_level (out_fill_level),
    .out_accepted   (out_accepted),
    .out_has_next   (out_has_next)
  );

  always #1 clk = ~clk;

  // Apply one operation to the shadow list and return the beat it must produce.
  function automatic list_result_t apply_list_op(list_op_t op);
    list_result_t r;
    int           i;
    r = '0;
    case (op.kind)
      KIND_APPEND: begin
        // drop the value when the list is full
        if (shadow_count < CMPL_CAPACITY) begin
          shadow_words[shadow_count] = op.value;
          shadow_count++;
          r.accepted = 1'b1;
        end
      end
      KIND_DELETE: begin
        // compact: every later entry moves down one slot
        if (int'(op.pos) < shadow_count) begin
          for (i = int'(op.pos); i + 1 < shadow_count; i++)
            shadow_words[i] = shadow_words[i + 1];
          shadow_count--;
          r.accepted = 1'b1;
        end
      end
      KIND_READ: begin
        if (int'(op.pos) < shadow_count) begin
          r.read_value = shadow_words[op.pos];
          r.accepted   = 1'b1;
        end
      end
      default: begin
        shadow_count = 0;
        r.accepted   = 1'b1;
      end
    endcase
    r.fill_level = FILL_W'(shadow_count);
    r.has_next   = (int'(op.pos) + 1 < shadow_count);
    return r;
  endfunction

  // Offer one beat after a random gap, hold it until accepted, then predict it.
  task automatic send_op(list_op_t op);
    list_result_t predicted;
    int           gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99, 0) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= op.kind;
    in_position <= op.pos;
    in_value    <= op.value;
    do @(posedge clk); while (in_stall);
    predicted = apply_list_op(op);
    pending_results.push_back(op.known ? op.known_res : predicted);
  endtask

  // Receiver: stall at random, except for one long hold-off that lets the
  // sender pile up against a busy block.
  always @(posedge clk) begin
    if (hold_request && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // Compare every taken result beat with the oldest pending prediction.
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_read_value);
          fail_count++;
        end
        if (out_fill_level !== want.fill_level) begin
          $error("fill_level: expected %0d, got %0d", want.fill_level, out_fill_level);
          fail_count++;
        end
        if (out_accepted !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, out_accepted);
          fail_count++;
        end
        if (out_has_next !== want.has_next) begin
          $error("has_next: expected %0b, got %0b", want.has_next, out_has_next);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    list_op_t op;
    int       n;
    int       pick;
    int       full_left;
    bit       filling;

    filling   = 1'b0;
    full_left = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles less than the receiver
    send_idle_pct = 29;
    recv_idle_pct = 46;

    foreach (DIRECTED_OPS[i])
      send_op(DIRECTED_OPS[i]);

    for (n = 0; n < RANDOM_OPS; n++) begin
      // Swap the idling, then run flat out with one long receiver hold-off
      if (n == RANDOM_OPS / 3) begin
        send_idle_pct = 46;
        recv_idle_pct = 29;
      end
      if (n == 2 * RANDOM_OPS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
      end
      // Grow the list to capacity once, linger at full, then go back to mixing
      if (n == RANDOM_OPS / 6) begin
        filling   = 1'b1;
        full_left = 12;
      end

      op       = '0;
      op.value = $urandom();
      pick     = $urandom_range(99, 0);
      if (filling) begin
        if (shadow_count == CMPL_CAPACITY) begin
          full_left--;
          if (full_left == 0)
            filling = 1'b0;
          op.kind = (pick < 50) ? KIND_APPEND : (pick < 90) ? KIND_READ : KIND_DELETE;
        end else begin
          op.kind = (pick < 90) ? KIND_APPEND : (pick < 98) ? KIND_READ : KIND_DELETE;
        end
      end else begin
        op.kind = (pick < 40) ? KIND_APPEND : (pick < 70) ? KIND_READ :
                  (pick < 95) ? KIND_DELETE : KIND_CLEAR;
      end

      // Mostly positions that hit the list, the rest anywhere in the field
      if (shadow_count > 0 && $urandom_range(99, 0) < 85)
        op.pos = POS_W'($urandom_range(shadow_count - 1, 0));
      else
        op.pos = POS_W'($urandom_range(255, 0));

      send_op(op);
    end

    in_valid <= 1'b0;

    // Drain, then give the block time to show any stray beat
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
